// ===== hw/rtl/ifu_pkg.sv =====
// Shared types and constants for the integer field update unit.
`timescale 1ns / 1ps
package ifu_pkg;

	typedef enum logic [1:0] {
		MODE_SET     = 2'd0,
		MODE_ADD     = 2'd1,
		MODE_OR      = 2'd2,
		MODE_SETBITS = 2'd3
	} mode_t;

	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	// largest column width in bytes that still gets clamped
	localparam logic [3:0] CLAMP_MAX_BYTES = 4'd7;
	// setbits field widths cap
	localparam logic [7:0] SETBITS_MAX_SIZE = 8'd32;

endpackage

// ===== hw/rtl/ifu_clamp.sv =====
// Clamp of a 64-bit value to the range of a signed or unsigned column.
`timescale 1ns / 1ps
module ifu_clamp
	import ifu_pkg::*;
(
	input  logic [63:0] value,
	input  logic        is_signed,
	input  logic [3:0]  bytes,
	output logic [63:0] clamped
);

	logic [5:0]  top_bit;
	logic [63:0] hi_s;
	logic [63:0] lo_s;
	logic [63:0] hi_u;
	logic        active;

	assign active  = (bytes != 4'd0) && (bytes <= CLAMP_MAX_BYTES);
	assign top_bit = {bytes[2:0], 3'b000} - 6'd1;
	assign hi_s    = (64'd1 << top_bit) - 64'd1;
	assign lo_s    = ~hi_s;
	assign hi_u    = {hi_s[62:0], 1'b1};

	always_comb begin
		clamped = value;
		if (active) begin
			if (is_signed) begin
				if ($signed(value) > $signed(hi_s)) begin
					clamped = hi_s;
				end else if ($signed(value) < $signed(lo_s)) begin
					clamped = lo_s;
				end
			end else begin
				if (value[63]) begin
					clamped = 64'd0;
				end else if (value > hi_u) begin
					clamped = hi_u;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/ifu_setbits.sv =====
// Masked bit range write driven by the size/offset/value fields of the operand.
`timescale 1ns / 1ps
module ifu_setbits
	import ifu_pkg::*;
(
	input  logic [63:0] old_value,
	input  logic [63:0] operand,
	output logic [63:0] new_value
);

	logic [7:0]  size_f;
	logic [23:0] off_f;
	logic [31:0] val_f;
	logic [5:0]  size_c;
	logic [5:0]  off_c;
	logic        skip;
	logic [63:0] ones;
	logic [63:0] mask;

	assign size_f = operand[63:56];
	assign off_f  = operand[55:32];
	assign val_f  = operand[31:0];
	assign skip   = (off_f >= 24'd64) || (size_f == 8'd0);
	assign size_c = (size_f > SETBITS_MAX_SIZE) ? SETBITS_MAX_SIZE[5:0] : size_f[5:0];
	assign off_c  = off_f[5:0];
	assign ones   = (64'd1 << size_c) - 64'd1;
	// bits shifted past bit 63 drop off, which cuts the range there
	assign mask   = ones << off_c;

	assign new_value = skip ? old_value
		: ((old_value & ~mask) | (({32'd0, val_f} << off_c) & mask));

endmodule

// ===== hw/rtl/integer_field_update_alu_core.sv =====
// Top level of the integer field update unit: input register, update logic, result register.
`timescale 1ns / 1ps
// A beat taken on start passes the input register, then the result register, which drives done.
// Throughput: one beat per cycle; busy is tied low, the two register stages never stall.
// The critical path is the 64-bit saturating add followed by the column clamp compare.
// Reset: arst_n low clears the stage valid flags at once; no result strobe until new beats arrive.
// The receiver cannot stall: each result stands on the ports for exactly one cycle.
module integer_field_update_alu_core
	import ifu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] old_value,
	input  logic        field_signed,
	input  logic [3:0]  field_bytes,
	input  logic [1:0]  mode,
	input  logic [63:0] operand,
	input  logic        operand_unsigned,
	output logic        done,
	output logic [63:0] new_value,
	output logic        supported
);

	// ---- input register stage ----
	logic        valid_s1;
	logic [63:0] old_s1;
	logic        fsigned_s1;
	logic [3:0]  fbytes_s1;
	mode_t       mode_s1;
	logic [63:0] operand_s1;
	logic        opuns_s1;

	// ---- result register stage ----
	logic        valid_s2;
	logic [63:0] value_s2;
	logic        supported_s2;

	// ---- update logic ----
	logic [63:0] sum;
	logic [63:0] sat_sum;
	logic [63:0] pre_clamp;
	logic [63:0] clamped;
	logic [63:0] bits_value;
	logic [63:0] next_value;
	logic        next_supported;

	// Nothing ever holds the input side off.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	// Payload: no reset needed, qualified by the valid flags.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			old_s1     <= old_value;
			fsigned_s1 <= field_signed;
			fbytes_s1  <= field_bytes;
			mode_s1    <= mode_t'(mode);
			operand_s1 <= operand;
			opuns_s1   <= operand_unsigned;
		end
		if (valid_s1) begin
			value_s2     <= next_value;
			supported_s2 <= next_supported;
		end
	end

	// Saturating 64-bit signed add: same-sign inputs with a flipped sign overflow.
	assign sum = old_s1 + operand_s1;
	always_comb begin
		sat_sum = sum;
		if (!old_s1[63] && !operand_s1[63] && sum[63]) begin
			sat_sum = S64_MAX;
		end else if (old_s1[63] && operand_s1[63] && !sum[63]) begin
			sat_sum = S64_MIN;
		end
	end

	always_comb begin
		case (mode_s1)
			MODE_SET: pre_clamp = operand_s1;
			MODE_ADD: pre_clamp = sat_sum;
			MODE_OR:  pre_clamp = old_s1 | operand_s1;
			default:  pre_clamp = operand_s1;
		endcase
	end

	ifu_clamp u_clamp (
		.value     (pre_clamp),
		.is_signed (fsigned_s1),
		.bytes     (fbytes_s1),
		.clamped   (clamped)
	);

	ifu_setbits u_setbits (
		.old_value (old_s1),
		.operand   (operand_s1),
		.new_value (bits_value)
	);

	// Support rules: set takes an unsigned operand only into an unsigned column;
	// add and or need a signed operand; setbits always applies.
	always_comb begin
		case (mode_s1)
			MODE_SET:     next_supported = !opuns_s1 || !fsigned_s1;
			MODE_ADD:     next_supported = !opuns_s1;
			MODE_OR:      next_supported = !opuns_s1;
			MODE_SETBITS: next_supported = 1'b1;
			default:      next_supported = 1'b1;
		endcase
		if (mode_s1 == MODE_SETBITS) begin
			next_value = bits_value;
		end else if (next_supported) begin
			next_value = clamped;
		end else begin
			next_value = old_s1;
		end
	end

	assign done      = valid_s2;
	assign new_value = value_s2;
	assign supported = supported_s2;

	// ---- assertions ----
	// every result strobe traces back to an input beat taken through both register stages
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result strobe without a matching input beat");

	// setbits is always handled
	a_setbits_supported: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(mode, 2) == MODE_SETBITS)) |-> supported)
		else $error("setbits result flagged unsupported");

	// an unsupported combination passes the old value through
	a_unsup_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !supported) |-> (new_value == $past(old_value, 2)))
		else $error("unsupported result changed the value");

	// an unsigned operand into a signed column is never supported outside setbits
	a_unsigned_rule: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(operand_unsigned, 2) && ($past(mode, 2) != MODE_SETBITS)
			&& $past(field_signed, 2)) |-> !supported)
		else $error("unsigned operand accepted into signed column");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the integer field update unit: predictor, scoreboard, stimulus.
`timescale 1ns / 1ps
module tb
	import ifu_pkg::*;
();

	// Generous ceiling for about 1500 beats, even if every gap were the longest one.
	localparam int unsigned CYCLE_LIMIT = 500000;
	// After the drain the bench idles on to catch stray result strobes.
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BEATS = 1450;

	typedef struct packed {
		logic [63:0] new_value;
		logic        supported;
	} update_t;

	// ------------------------------------------------------------------
	// Scoreboard: predicts every accepted beat and checks results in order.
	// ------------------------------------------------------------------
	class update_ledger;
		update_t pending_updates[$];
		int      mismatches;
		int      results_checked;

		function new();
			mismatches      = 0;
			results_checked = 0;
		endfunction

		// Saturate v to the range of a column of n bytes; widths 1..7 only.
		function logic [63:0] clamp_column(logic [63:0] v, logic sgn, logic [3:0] n);
			logic [63:0] hi;
			logic [63:0] lo;
			int unsigned bits;
			if (n < 4'd1 || n > CLAMP_MAX_BYTES) begin
				return v;
			end
			bits = 8 * n;
			if (sgn) begin
				hi = (64'd1 << (bits - 1)) - 64'd1;
				lo = ~hi;
				if (v[63]) begin
					return (v < lo) ? lo : v;
				end
				return (v > hi) ? hi : v;
			end
			hi = (64'd1 << bits) - 64'd1;
			if (v[63]) begin
				return 64'd0;
			end
			return (v > hi) ? hi : v;
		endfunction

		// 64-bit signed add that sticks at the limits on overflow.
		function logic [63:0] add_saturated(logic [63:0] a, logic [63:0] b);
			logic [63:0] sum;
			sum = a + b;
			if (!a[63] && !b[63] && sum[63]) begin
				return S64_MAX;
			end
			if (a[63] && b[63] && !sum[63]) begin
				return S64_MIN;
			end
			return sum;
		endfunction

		// Replace a bit range of v; size, offset and value are packed in op.
		function logic [63:0] write_bit_range(logic [63:0] v, logic [63:0] op);
			int unsigned size;
			int unsigned off;
			logic [63:0] mask;
			logic [63:0] value;
			size  = 32'(op[63:56]);
			off   = 32'(op[55:32]);
			value = {32'd0, op[31:0]};
			if (off >= 64 || size == 0) begin
				return v;
			end
			if (size > SETBITS_MAX_SIZE) begin
				size = 32'(SETBITS_MAX_SIZE);
			end
			if (size > 64 - off) begin
				size = 64 - off;
			end
			mask = ((64'd1 << size) - 64'd1) << off;
			return (v & ~mask) | ((value << off) & mask);
		endfunction

		function update_t predict_update(logic [63:0] ov, logic fs, logic [3:0] fb,
				logic [1:0] md, logic [63:0] op, logic opu);
			update_t u;
			u.new_value = ov;
			u.supported = 1'b0;
			case (mode_t'(md))
				MODE_SET: begin
					// signed column refuses an unsigned operand
					if (!opu || !fs) begin
						u.new_value = clamp_column(op, fs, fb);
						u.supported = 1'b1;
					end
				end
				MODE_ADD: begin
					if (!opu) begin
						u.new_value = clamp_column(add_saturated(ov, op), fs, fb);
						u.supported = 1'b1;
					end
				end
				MODE_OR: begin
					if (!opu) begin
						u.new_value = clamp_column(ov | op, fs, fb);
						u.supported = 1'b1;
					end
				end
				default: begin
					u.new_value = write_bit_range(ov, op);
					u.supported = 1'b1;
				end
			endcase
			return u;
		endfunction

		task report(string what);
			$display("MISMATCH: %s", what);
			mismatches++;
		endtask

		function void note_beat(logic [63:0] ov, logic fs, logic [3:0] fb, logic [1:0] md,
				logic [63:0] op, logic opu);
			pending_updates.push_back(predict_update(ov, fs, fb, md, op, opu));
		endfunction

		task check_result(logic [63:0] nv, logic sup);
			update_t want;
			if (pending_updates.size() == 0) begin
				report($sformatf("result %h/%b with no beat outstanding", nv, sup));
				return;
			end
			want = pending_updates.pop_front();
			results_checked++;
			if (nv !== want.new_value) begin
				report($sformatf("new_value %h, predicted %h", nv, want.new_value));
			end
			if (sup !== want.supported) begin
				report($sformatf("supported %b, predicted %b", sup, want.supported));
			end
		endtask

		function int pending_count();
			return pending_updates.size();
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT and its ports
	// ------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] old_value;
	logic        field_signed;
	logic [3:0]  field_bytes;
	logic [1:0]  mode;
	logic [63:0] operand;
	logic        operand_unsigned;
	logic        done;
	logic [63:0] new_value;
	logic        supported;

	integer_field_update_alu_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.old_value        (old_value),
		.field_signed     (field_signed),
		.field_bytes      (field_bytes),
		.mode             (mode),
		.operand          (operand),
		.operand_unsigned (operand_unsigned),
		.done             (done),
		.new_value        (new_value),
		.supported        (supported)
	);

	update_ledger ledger;
	int          beats_sent = 0;
	int unsigned cycle_count = 0;

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Monitor. Everything here samples pre-edge values, since the driver updates
	// inputs with nonblocking assignments at the same edge. The result strobe
	// cannot be held off, so each done cycle is one result beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				ledger.check_result(new_value, supported);
			end
			if (start && !busy) begin
				ledger.note_beat(old_value, field_signed, field_bytes, mode, operand,
					operand_unsigned);
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------

	// Present one beat, hold it until taken, then lower start and idle for the given gap, if any.
	// With gap 0 start stays high into the next call, so it is never lowered
	// and raised at the same edge.
	task automatic send_beat(input logic [63:0] ov, input logic fs, input logic [3:0] fb,
			input mode_t md, input logic [63:0] op, input logic opu, input int gap);
		start            <= 1'b1;
		old_value        <= ov;
		field_signed     <= fs;
		field_bytes      <= fb;
		mode             <= md;
		operand          <= op;
		operand_unsigned <= opu;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		beats_sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted result has been checked.
	// The first edge makes sure the last accepted beat is already in the ledger.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (ledger.pending_count() != 0) begin
			@(posedge clk);
		end
	endtask

	// Pack a setbits operand: size 63..56, offset 55..32, value 31..0.
	function automatic logic [63:0] bits_op(logic [7:0] size, logic [23:0] off, logic [31:0] val);
		return {size, off, val};
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Values biased toward the 64-bit extremes and the column clamp boundaries.
	function automatic logic [63:0] pick_value(logic [3:0] fb, logic fs);
		logic [63:0] lim;
		logic [63:0] nudge;
		int unsigned bits;
		nudge = 64'($urandom_range(0, 3));
		case ($urandom_range(0, 11))
			0: return 64'd0;
			1: return '1;
			2: return S64_MAX - nudge;
			3: return S64_MIN + nudge;
			4: return {56'd0, 8'($urandom)};
			5: return -{56'd0, 8'($urandom)};
			6, 7: begin
				// just around the column limit, either sign
				bits = (fb >= 4'd1 && fb <= 4'd8) ? 8 * fb : 64;
				if (bits == 64) begin
					lim = S64_MAX;
				end else begin
					lim = fs ? (64'd1 << (bits - 1)) : (64'd1 << bits);
				end
				lim = $urandom_range(0, 1) ? (lim + nudge - 64'd2) : (-lim + nudge - 64'd2);
				return lim;
			end
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic run_random(input int count);
		logic [63:0] ov;
		logic [63:0] op;
		logic [3:0]  fb;
		logic        fs;
		logic        opu;
		mode_t       md;
		logic [7:0]  sz;
		logic [23:0] off;
		bit          burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			// stretches of back-to-back beats with no idling at all
			if (i % 100 == 0) begin
				burst = ($urandom_range(0, 3) == 0);
			end
			// mid-run: let the pipe run dry before carrying on
			if (i == count / 2) begin
				wait_drained();
			end
			fs  = 1'($urandom_range(0, 1));
			fb  = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
			md  = mode_t'($urandom_range(0, 3));
			opu = ($urandom_range(0, 99) < 30);
			ov  = pick_value(fb, fs);
			if (md == MODE_SETBITS) begin
				if ($urandom_range(0, 99) < 80) begin
					// well-formed range, sizes at and past the cap
					case ($urandom_range(0, 9))
						0:       sz = 8'd0;
						1:       sz = 8'($urandom_range(33, 255));
						default: sz = 8'($urandom_range(1, 32));
					endcase
					off = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(64, 24'hFFFFFF))
						: 24'($urandom_range(0, 63));
					op  = bits_op(sz, off, $urandom);
				end else begin
					op = {$urandom, $urandom};
				end
			end else begin
				op = pick_value(fb, fs);
			end
			send_beat(ov, fs, fb, md, op, opu, burst ? 0 : pick_gap());
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		ledger           = new();
		arst_n           = 1'b0;
		start            = 1'b0;
		old_value        = '0;
		field_signed     = 1'b0;
		field_bytes      = '0;
		mode             = MODE_SET;
		operand          = '0;
		operand_unsigned = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: clamps per column width, unsupported combinations,
		// add overflow both ways, and the setbits skip and cut cases.
		send_beat(64'd5, 1'b1, 4'd1, MODE_SET, 64'd300, 1'b0, 0);
		send_beat(64'd5, 1'b1, 4'd1, MODE_SET, -64'd300, 1'b0, 0);
		send_beat(64'd5, 1'b0, 4'd2, MODE_SET, -64'd1, 1'b0, 1);
		send_beat(64'd5, 1'b0, 4'd7, MODE_SET, S64_MAX, 1'b1, 0);
		send_beat(64'd5, 1'b1, 4'd8, MODE_SET, S64_MIN, 1'b0, 0);
		send_beat(64'd5, 1'b1, 4'd0, MODE_SET, S64_MAX, 1'b0, 0);
		send_beat(64'd5, 1'b0, 4'd15, MODE_SET, S64_MIN, 1'b0, 2);
		// signed column, unsigned operand: refused
		send_beat(64'd5, 1'b1, 4'd4, MODE_SET, 64'd9, 1'b1, 0);
		// add overflow: positive, negative, two most negative values
		send_beat(S64_MAX, 1'b1, 4'd8, MODE_ADD, 64'd1, 1'b0, 0);
		send_beat(S64_MIN, 1'b1, 4'd8, MODE_ADD, -64'd1, 1'b0, 0);
		send_beat(S64_MIN, 1'b1, 4'd8, MODE_ADD, S64_MIN, 1'b0, 0);
		send_beat(64'd32760, 1'b1, 4'd2, MODE_ADD, 64'd100, 1'b0, 0);
		send_beat(64'd10, 1'b0, 4'd3, MODE_ADD, 64'd1, 1'b1, 3);
		send_beat(64'hF0, 1'b0, 4'd1, MODE_OR, 64'h0F00, 1'b0, 0);
		send_beat('1, 1'b1, 4'd8, MODE_OR, S64_MAX, 1'b0, 0);
		send_beat(64'hF0, 1'b1, 4'd1, MODE_OR, 64'h1, 1'b1, 0);
		// setbits: plain, offset too large, size zero, size past cap, cut at bit 63
		send_beat('0, 1'b0, 4'd1, MODE_SETBITS, bits_op(8'd8, 24'd4, 32'hFFFF_FFFF), 1'b0, 0);
		send_beat(64'h1234, 1'b1, 4'd2, MODE_SETBITS, bits_op(8'd8, 24'd64, 32'hFF), 1'b0, 0);
		send_beat(64'h1234, 1'b1, 4'd2, MODE_SETBITS, bits_op(8'd8, 24'hFFFFFF, 32'hFF), 1'b1, 0);
		send_beat(64'h1234, 1'b0, 4'd2, MODE_SETBITS, bits_op(8'd0, 24'd3, 32'hFF), 1'b1, 0);
		send_beat('0, 1'b1, 4'd1, MODE_SETBITS, bits_op(8'hFF, 24'd16, 32'hDEAD_BEEF), 1'b1, 0);
		send_beat('0, 1'b0, 4'd8, MODE_SETBITS, bits_op(8'd16, 24'd60, 32'hFFFF), 1'b0, 0);
		send_beat('1, 1'b1, 4'd3, MODE_SETBITS, bits_op(8'd32, 24'd32, 32'h0), 1'b0, 0);
		send_beat('1, 1'b0, 4'd8, MODE_SETBITS, bits_op(8'd1, 24'd63, 32'h0), 1'b1, 5);
		wait_drained();

		run_random(RANDOM_BEATS);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d beats sent, %0d results checked, %0d mismatches",
			beats_sent, ledger.results_checked, ledger.mismatches);
		$display("summary: all modes, column widths 0..15, add overflow and setbits limits");
		if (ledger.mismatches == 0 && ledger.pending_count() == 0) begin
			$display("tb: success");
		end else begin
			if (ledger.pending_count() != 0) begin
				$display("MISMATCH: %0d results never arrived", ledger.pending_count());
			end
			$display("tb: failure");
		end
		$finish;
	end

endmodule
